// ===== rtl/radtan_lens_distortion_top_defines.svh =====
// assertion macros shared by the rtl
`ifndef RADTAN_LENS_DISTORTION_TOP_DEFINES_SVH
`define RADTAN_LENS_DISTORTION_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RTLD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RTLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rtld_pkg.sv =====
package rtld_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ITERATIONS = 5;
  localparam int XW = 66;
  localparam int QBITS = 33;
  localparam int NW = 2 * FRAC_BITS + 1;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [63:0] prod_t;

  localparam q32_t Q_MAX = 32'sh7fffffff;
  localparam q32_t Q_MIN = 32'sh80000000;
  localparam q32_t Q_ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] SMALL_LIM = 32'(64'd1 << (2 * FRAC_BITS - 32));

  typedef enum logic [1:0] {
    K_DIST   = 2'd0,
    K_UNDIST = 2'd1,
    K_JAC    = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;

  localparam logic [1:0] REG_K1 = 2'd0;
  localparam logic [1:0] REG_K2 = 2'd1;
  localparam logic [1:0] REG_P1 = 2'd2;
  localparam logic [1:0] REG_P2 = 2'd3;

  typedef struct packed {
    logic sat;
    q32_t val;
  } qres_t;

  typedef struct packed {
    q32_t k1;
    q32_t k2;
    q32_t p1;
    q32_t p2;
  } coef_t;

  typedef struct packed {
    logic [1:0] kind;
    q32_t       u;
    q32_t       v;
    q32_t       cu;
    q32_t       cv;
    logic       isat;
    logic       zd;
    q32_t       rx;
    q32_t       ry;
    q32_t       rc;
    logic       fsat;
  } item_t;

  typedef struct packed {
    item_t item;
    q32_t  nx;
    q32_t  ny;
    logic  dneg;
    logic  zero;
    logic  small_d;
    logic  sat;
  } div_pay_t;

  function automatic qres_t clamp(input logic signed [XW-1:0] x);
    qres_t r;
    if (x > XW'(Q_MAX)) begin
      r.sat = 1'b1;
      r.val = Q_MAX;
    end else if (x < XW'(Q_MIN)) begin
      r.sat = 1'b1;
      r.val = Q_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = x[31:0];
    end
    return r;
  endfunction

  function automatic qres_t qadd(input q32_t a, input q32_t b);
    return clamp(XW'(a) + XW'(b));
  endfunction

  function automatic qres_t qsub(input q32_t a, input q32_t b);
    return clamp(XW'(a) - XW'(b));
  endfunction

  function automatic qres_t qsc2(input q32_t a);
    return clamp(XW'(a) <<< 1);
  endfunction

  function automatic qres_t qsc4(input q32_t a);
    return clamp(XW'(a) <<< 2);
  endfunction

  function automatic qres_t qsc6(input q32_t a);
    return clamp((XW'(a) <<< 2) + (XW'(a) <<< 1));
  endfunction

  function automatic prod_t mul(input q32_t a, input q32_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // round half up, then saturate
  function automatic qres_t qfin(input prod_t p);
    logic signed [XW-1:0] t;
    t = (XW'(p) + (XW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clamp(t);
  endfunction

endpackage

// ===== rtl/rtld_front.sv =====
module rtld_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  rtld_pkg::coef_t      coef,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  input  rtld_pkg::q32_t       in_u,
  input  rtld_pkg::q32_t       in_v,
  output logic                 out_valid,
  output rtld_pkg::item_t      out_item
);

  logic v1, v2, v3, v4;

  logic [1:0] st1_kind, st2_kind, st3_kind, st4_kind;
  rtld_pkg::q32_t st1_u, st1_v, st2_u, st2_v, st3_u, st3_v, st4_u, st4_v;
  rtld_pkg::prod_t st1_puu, st1_pvv, st1_puv;

  rtld_pkg::q32_t st2_u2, st2_v2, st2_uv, st2_r2;
  logic st2_sd, st2_sj;
  rtld_pkg::prod_t st2_pk2r2, st2_pp1uvt2, st2_pp2tu, st2_pp2uvt2, st2_pp1tv;
  rtld_pkg::prod_t st2_pk1u2, st2_pk1v2, st2_pk1uv, st2_pp1v, st2_pp2u, st2_pp1u, st2_pp2v;

  logic st3_sd, st3_sj;
  rtld_pkg::prod_t st3_pc, st3_pt4u2, st3_pt4v2, st3_pt4uv;
  rtld_pkg::q32_t st3_da, st3_db, st3_dc, st3_dd;
  rtld_pkg::q32_t st3_j1, st3_j2, st3_j3, st3_j4, st3_j5, st3_j6, st3_j7, st3_j8, st3_j9;

  logic st4_sd, st4_sj;
  rtld_pkg::prod_t st4_puc, st4_pvc;
  rtld_pkg::q32_t st4_da, st4_db, st4_dc, st4_dd;
  rtld_pkg::q32_t st4_jx, st4_jy, st4_jc, st4_j4, st4_j5, st4_j6, st4_j7, st4_j9;

  // stage 2 logic
  rtld_pkg::qres_t u2, v2q, uv, r2, uvt2, su, tu, sv, tv;
  always_comb begin
    u2   = rtld_pkg::qfin(st1_puu);
    v2q  = rtld_pkg::qfin(st1_pvv);
    uv   = rtld_pkg::qfin(st1_puv);
    r2   = rtld_pkg::qadd(u2.val, v2q.val);
    uvt2 = rtld_pkg::qsc2(uv.val);
    su   = rtld_pkg::qsc2(u2.val);
    tu   = rtld_pkg::qadd(r2.val, su.val);
    sv   = rtld_pkg::qsc2(v2q.val);
    tv   = rtld_pkg::qadd(r2.val, sv.val);
  end

  // stage 3 logic
  rtld_pkg::qres_t k2r2, s3, t4, da, db, dc, dd;
  rtld_pkg::qres_t f1, f2, f3, f4, f5, f6, f7, f8;
  rtld_pkg::qres_t j1, j2, j3, j4, j5, j6, j7, j8, j9;
  always_comb begin
    k2r2 = rtld_pkg::qfin(st2_pk2r2);
    s3   = rtld_pkg::qadd(coef.k1, k2r2.val);
    t4   = rtld_pkg::qsc4(k2r2.val);
    da   = rtld_pkg::qfin(st2_pp1uvt2);
    db   = rtld_pkg::qfin(st2_pp2tu);
    dc   = rtld_pkg::qfin(st2_pp2uvt2);
    dd   = rtld_pkg::qfin(st2_pp1tv);
    f1   = rtld_pkg::qfin(st2_pk1u2);
    f2   = rtld_pkg::qfin(st2_pk1v2);
    f3   = rtld_pkg::qfin(st2_pk1uv);
    f4   = rtld_pkg::qfin(st2_pp1v);
    f5   = rtld_pkg::qfin(st2_pp2u);
    f6   = rtld_pkg::qfin(st2_pp1u);
    f7   = rtld_pkg::qfin(st2_pp2v);
    f8   = f5;
    j1   = rtld_pkg::qsc2(f1.val);
    j2   = rtld_pkg::qsc2(f2.val);
    j3   = rtld_pkg::qsc2(f3.val);
    j4   = rtld_pkg::qsc2(f4.val);
    j5   = rtld_pkg::qsc6(f5.val);
    j6   = rtld_pkg::qsc2(f8.val);
    j7   = rtld_pkg::qsc6(f4.val);
    j8   = rtld_pkg::qsc2(f6.val);
    j9   = rtld_pkg::qsc2(f7.val);
  end

  // stage 4 logic
  rtld_pkg::qres_t cr, c1, ju, jv, juv, jx0, jx, jy0, jy, jc0, jc;
  always_comb begin
    cr  = rtld_pkg::qfin(st3_pc);
    c1  = rtld_pkg::qadd(cr.val, rtld_pkg::Q_ONE);
    ju  = rtld_pkg::qfin(st3_pt4u2);
    jv  = rtld_pkg::qfin(st3_pt4v2);
    juv = rtld_pkg::qfin(st3_pt4uv);
    jx0 = rtld_pkg::qadd(c1.val, st3_j1);
    jx  = rtld_pkg::qadd(jx0.val, ju.val);
    jy0 = rtld_pkg::qadd(c1.val, st3_j2);
    jy  = rtld_pkg::qadd(jy0.val, jv.val);
    jc0 = rtld_pkg::qadd(st3_j3, juv.val);
    jc  = rtld_pkg::qadd(jc0.val, st3_j8);
  end

  // stage 5 logic
  rtld_pkg::qres_t uc, vc, x0, x1, x2, y0, y1, y2, jx1, jx2, jy1, jy2, jc2;
  rtld_pkg::item_t item_next;
  always_comb begin
    uc  = rtld_pkg::qfin(st4_puc);
    vc  = rtld_pkg::qfin(st4_pvc);
    x0  = rtld_pkg::qadd(st4_u, uc.val);
    x1  = rtld_pkg::qadd(x0.val, st4_da);
    x2  = rtld_pkg::qadd(x1.val, st4_db);
    y0  = rtld_pkg::qadd(st4_v, vc.val);
    y1  = rtld_pkg::qadd(y0.val, st4_dc);
    y2  = rtld_pkg::qadd(y1.val, st4_dd);
    jx1 = rtld_pkg::qadd(st4_jx, st4_j4);
    jx2 = rtld_pkg::qadd(jx1.val, st4_j5);
    jy1 = rtld_pkg::qadd(st4_jy, st4_j6);
    jy2 = rtld_pkg::qadd(jy1.val, st4_j7);
    jc2 = rtld_pkg::qadd(st4_jc, st4_j9);
    item_next      = '0;
    item_next.kind = st4_kind;
    item_next.u    = st4_u;
    item_next.v    = st4_v;
    item_next.cu   = st4_u;
    item_next.cv   = st4_v;
    case (st4_kind)
      rtld_pkg::K_DIST: begin
        item_next.rx   = x2.val;
        item_next.ry   = y2.val;
        item_next.fsat = st4_sd | uc.sat | vc.sat | x0.sat | x1.sat | x2.sat
                         | y0.sat | y1.sat | y2.sat;
      end
      rtld_pkg::K_JAC: begin
        item_next.rx   = jx2.val;
        item_next.ry   = jy2.val;
        item_next.rc   = jc2.val;
        item_next.fsat = st4_sj | jx1.sat | jx2.sat | jy1.sat | jy2.sat | jc2.sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_kind <= in_kind;
      st1_u    <= in_u;
      st1_v    <= in_v;
      st1_puu  <= rtld_pkg::mul(in_u, in_u);
      st1_pvv  <= rtld_pkg::mul(in_v, in_v);
      st1_puv  <= rtld_pkg::mul(in_u, in_v);

      st2_kind    <= st1_kind;
      st2_u       <= st1_u;
      st2_v       <= st1_v;
      st2_u2      <= u2.val;
      st2_v2      <= v2q.val;
      st2_uv      <= uv.val;
      st2_r2      <= r2.val;
      st2_sd      <= u2.sat | v2q.sat | uv.sat | r2.sat | uvt2.sat | su.sat | tu.sat
                     | sv.sat | tv.sat;
      st2_sj      <= u2.sat | v2q.sat | uv.sat | r2.sat;
      st2_pk2r2   <= rtld_pkg::mul(coef.k2, r2.val);
      st2_pp1uvt2 <= rtld_pkg::mul(coef.p1, uvt2.val);
      st2_pp2tu   <= rtld_pkg::mul(coef.p2, tu.val);
      st2_pp2uvt2 <= rtld_pkg::mul(coef.p2, uvt2.val);
      st2_pp1tv   <= rtld_pkg::mul(coef.p1, tv.val);
      st2_pk1u2   <= rtld_pkg::mul(coef.k1, u2.val);
      st2_pk1v2   <= rtld_pkg::mul(coef.k1, v2q.val);
      st2_pk1uv   <= rtld_pkg::mul(coef.k1, uv.val);
      st2_pp1v    <= rtld_pkg::mul(coef.p1, st1_v);
      st2_pp2u    <= rtld_pkg::mul(coef.p2, st1_u);
      st2_pp1u    <= rtld_pkg::mul(coef.p1, st1_u);
      st2_pp2v    <= rtld_pkg::mul(coef.p2, st1_v);

      st3_kind  <= st2_kind;
      st3_u     <= st2_u;
      st3_v     <= st2_v;
      st3_sd    <= st2_sd | k2r2.sat | s3.sat | da.sat | db.sat | dc.sat | dd.sat;
      st3_sj    <= st2_sj | k2r2.sat | s3.sat | t4.sat | f1.sat | f2.sat | f3.sat | f4.sat
                   | f5.sat | f6.sat | f7.sat | j1.sat | j2.sat | j3.sat | j4.sat | j5.sat
                   | j6.sat | j7.sat | j8.sat | j9.sat;
      st3_pc    <= rtld_pkg::mul(s3.val, st2_r2);
      st3_pt4u2 <= rtld_pkg::mul(t4.val, st2_u2);
      st3_pt4v2 <= rtld_pkg::mul(t4.val, st2_v2);
      st3_pt4uv <= rtld_pkg::mul(t4.val, st2_uv);
      st3_da    <= da.val;
      st3_db    <= db.val;
      st3_dc    <= dc.val;
      st3_dd    <= dd.val;
      st3_j1    <= j1.val;
      st3_j2    <= j2.val;
      st3_j3    <= j3.val;
      st3_j4    <= j4.val;
      st3_j5    <= j5.val;
      st3_j6    <= j6.val;
      st3_j7    <= j7.val;
      st3_j8    <= j8.val;
      st3_j9    <= j9.val;

      st4_kind <= st3_kind;
      st4_u    <= st3_u;
      st4_v    <= st3_v;
      st4_sd   <= st3_sd | cr.sat;
      st4_sj   <= st3_sj | cr.sat | c1.sat | ju.sat | jv.sat | juv.sat | jx0.sat | jx.sat
                  | jy0.sat | jy.sat | jc0.sat | jc.sat;
      st4_puc  <= rtld_pkg::mul(st3_u, cr.val);
      st4_pvc  <= rtld_pkg::mul(st3_v, cr.val);
      st4_da   <= st3_da;
      st4_db   <= st3_db;
      st4_dc   <= st3_dc;
      st4_dd   <= st3_dd;
      st4_jx   <= jx.val;
      st4_jy   <= jy.val;
      st4_jc   <= jc.val;
      st4_j4   <= st3_j4;
      st4_j5   <= st3_j5;
      st4_j6   <= st3_j6;
      st4_j7   <= st3_j7;
      st4_j9   <= st3_j9;

      out_item <= item_next;
    end
  end

endmodule

// ===== rtl/rtld_div.sv =====
module rtld_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  rtld_pkg::div_pay_t            in_pay,
  input  logic [31:0]                   in_mag,
  input  logic [31:0]                   in_rem,
  input  logic [rtld_pkg::QBITS-1:0]    in_low,
  output logic                          out_valid,
  output rtld_pkg::div_pay_t            out_pay,
  output logic [rtld_pkg::QBITS-1:0]    out_q
);

  localparam int N = rtld_pkg::QBITS;

  logic               vld [N];
  rtld_pkg::div_pay_t pay [N];
  logic [31:0]        mag [N];
  logic [31:0]        rem [N];
  logic [N-1:0]       low [N];
  logic [N-1:0]       quo [N];

  // one quotient bit per cell
  for (genvar j = 0; j < N; j++) begin : g_cell
    logic               pv;
    rtld_pkg::div_pay_t pp;
    logic [31:0]        pm;
    logic [31:0]        pr;
    logic [N-1:0]       pl;
    logic [N-1:0]       pq;
    logic [32:0]        trial;
    logic               ge;

    if (j == 0) begin : g_first
      assign pv = in_valid;
      assign pp = in_pay;
      assign pm = in_mag;
      assign pr = in_rem;
      assign pl = in_low;
      assign pq = '0;
    end else begin : g_rest
      assign pv = vld[j-1];
      assign pp = pay[j-1];
      assign pm = mag[j-1];
      assign pr = rem[j-1];
      assign pl = low[j-1];
      assign pq = quo[j-1];
    end

    assign trial = {pr, pl[N-1]};
    assign ge    = trial >= {1'b0, pm};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pay[j] <= pp;
        mag[j] <= pm;
        rem[j] <= ge ? 32'(trial - {1'b0, pm}) : trial[31:0];
        low[j] <= pl << 1;
        quo[j] <= {pq[N-2:0], ge};
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_pay   = pay[N-1];
  assign out_q     = quo[N-1];

endmodule

// ===== rtl/rtld_iter.sv =====
module rtld_iter (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rtld_pkg::coef_t coef,
  input  logic            in_valid,
  input  rtld_pkg::item_t in_item,
  output logic            out_valid,
  output rtld_pkg::item_t out_item
);

  localparam int XW = rtld_pkg::XW;
  localparam int NW = rtld_pkg::NW;
  localparam int QB = rtld_pkg::QBITS;

  logic va, vb, vc, ve;
  rtld_pkg::item_t a_it, b_it, c_it, e_it;
  rtld_pkg::prod_t a_puu, a_pvv, a_puv;
  rtld_pkg::q32_t  b_r2;
  logic            b_sat, c_sat, e_sat;
  rtld_pkg::prod_t b_pk2r2, b_pp1uvt2, b_pp2tu, b_pp2uvt2, b_pp1tv;
  rtld_pkg::prod_t c_ps;
  rtld_pkg::q32_t  c_nx, c_ny, e_nx, e_ny;
  logic            e_zero;
  rtld_pkg::prod_t e_mx, e_my;

  // stage b logic
  rtld_pkg::qres_t u2, v2q, uv, uvt2, r2, su, tu, sv, tv;
  always_comb begin
    u2   = rtld_pkg::qfin(a_puu);
    v2q  = rtld_pkg::qfin(a_pvv);
    uv   = rtld_pkg::qfin(a_puv);
    uvt2 = rtld_pkg::qsc2(uv.val);
    r2   = rtld_pkg::qadd(u2.val, v2q.val);
    su   = rtld_pkg::qsc2(u2.val);
    tu   = rtld_pkg::qadd(r2.val, su.val);
    sv   = rtld_pkg::qsc2(v2q.val);
    tv   = rtld_pkg::qadd(r2.val, sv.val);
  end

  // stage c logic
  rtld_pkg::qres_t k2r2, s, m1, m2, m3, m4, du, dv, nx, ny;
  always_comb begin
    k2r2 = rtld_pkg::qfin(b_pk2r2);
    s    = rtld_pkg::qadd(coef.k1, k2r2.val);
    m1   = rtld_pkg::qfin(b_pp1uvt2);
    m2   = rtld_pkg::qfin(b_pp2tu);
    m3   = rtld_pkg::qfin(b_pp2uvt2);
    m4   = rtld_pkg::qfin(b_pp1tv);
    du   = rtld_pkg::qadd(m1.val, m2.val);
    dv   = rtld_pkg::qadd(m3.val, m4.val);
    nx   = rtld_pkg::qsub(b_it.u, du.val);
    ny   = rtld_pkg::qsub(b_it.v, dv.val);
  end

  // divisor and divider feed
  rtld_pkg::qres_t    rt, d;
  logic [32:0]        m33;
  logic [31:0]        mag;
  logic [NW-1:0]      num;
  rtld_pkg::div_pay_t dpay;
  always_comb begin
    rt  = rtld_pkg::qfin(c_ps);
    d   = rtld_pkg::qadd(rtld_pkg::Q_ONE, rt.val);
    m33 = d.val[31] ? -33'(d.val) : 33'(d.val);
    mag = m33[31:0];
    num = (NW'(1) << (2 * rtld_pkg::FRAC_BITS)) + NW'(mag >> 1);
    dpay.item    = c_it;
    dpay.nx      = c_nx;
    dpay.ny      = c_ny;
    dpay.dneg    = d.val[31];
    dpay.zero    = d.val == '0;
    dpay.small_d = mag < rtld_pkg::SMALL_LIM;
    dpay.sat     = c_sat | rt.sat | d.sat;
  end

  logic               dv_out;
  rtld_pkg::div_pay_t dp_out;
  logic [QB-1:0]      q_out;

  rtld_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc),
    .in_pay    (dpay),
    .in_mag    (mag),
    .in_rem    (32'(num >> QB)),
    .in_low    (num[QB-1:0]),
    .out_valid (dv_out),
    .out_pay   (dp_out),
    .out_q     (q_out)
  );

  // reciprocal sign and saturation
  logic signed [XW-1:0] qx;
  rtld_pkg::qres_t      inv;
  always_comb begin
    qx = XW'(q_out);
    if (dp_out.small_d) begin
      inv.sat = 1'b1;
      inv.val = dp_out.dneg ? rtld_pkg::Q_MIN : rtld_pkg::Q_MAX;
    end else begin
      inv = rtld_pkg::clamp(dp_out.dneg ? -qx : qx);
    end
  end

  // iterate update
  rtld_pkg::qres_t fx, fy;
  rtld_pkg::item_t item_next;
  always_comb begin
    fx = rtld_pkg::qfin(e_mx);
    fy = rtld_pkg::qfin(e_my);
    item_next = e_it;
    if (e_it.kind == rtld_pkg::K_UNDIST && !e_it.zd) begin
      if (e_zero) begin
        item_next.zd = 1'b1;
        item_next.cu = e_nx[31] ? rtld_pkg::Q_MIN : rtld_pkg::Q_MAX;
        item_next.cv = e_ny[31] ? rtld_pkg::Q_MIN : rtld_pkg::Q_MAX;
      end else begin
        item_next.cu   = fx.val;
        item_next.cv   = fy.val;
        item_next.isat = e_it.isat | e_sat | fx.sat | fy.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      ve <= dv_out;
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_it  <= in_item;
      a_puu <= rtld_pkg::mul(in_item.cu, in_item.cu);
      a_pvv <= rtld_pkg::mul(in_item.cv, in_item.cv);
      a_puv <= rtld_pkg::mul(in_item.cu, in_item.cv);

      b_it      <= a_it;
      b_r2      <= r2.val;
      b_sat     <= u2.sat | v2q.sat | uv.sat | uvt2.sat | r2.sat | su.sat | tu.sat
                   | sv.sat | tv.sat;
      b_pk2r2   <= rtld_pkg::mul(coef.k2, r2.val);
      b_pp1uvt2 <= rtld_pkg::mul(coef.p1, uvt2.val);
      b_pp2tu   <= rtld_pkg::mul(coef.p2, tu.val);
      b_pp2uvt2 <= rtld_pkg::mul(coef.p2, uvt2.val);
      b_pp1tv   <= rtld_pkg::mul(coef.p1, tv.val);

      c_it  <= b_it;
      c_sat <= b_sat | k2r2.sat | s.sat | m1.sat | m2.sat | m3.sat | m4.sat | du.sat
               | dv.sat | nx.sat | ny.sat;
      c_ps  <= rtld_pkg::mul(s.val, b_r2);
      c_nx  <= nx.val;
      c_ny  <= ny.val;

      e_it   <= dp_out.item;
      e_nx   <= dp_out.nx;
      e_ny   <= dp_out.ny;
      e_zero <= dp_out.zero;
      e_sat  <= dp_out.sat | inv.sat;
      e_mx   <= rtld_pkg::mul(dp_out.nx, inv.val);
      e_my   <= rtld_pkg::mul(dp_out.ny, inv.val);

      out_item <= item_next;
    end
  end

endmodule

// ===== rtl/radtan_lens_distortion_top.sv =====
// channel  handshake               word
// in       in_valid / in_stall     kind, in_u, in_v
// out      out_valid / out_stall   result_x, result_y, cross_term, status
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
// one word per cycle unless out_stall freezes the pipeline
// each iteration cell holds a 33-cell restoring divider, which dominates the latency
// rst is synchronous and clears valid bits and coefficients
// out_stall with a word waiting freezes the pipeline and raises in_stall
`include "radtan_lens_distortion_top_defines.svh"

module radtan_lens_distortion_top #(
  parameter int ITERATIONS = rtld_pkg::ITERATIONS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] in_u,
  input  logic signed [31:0] in_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_x,
  output logic signed [31:0] result_y,
  output logic signed [31:0] cross_term,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  rtld_pkg::coef_t coef;
  logic            en;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtld_pkg::REG_K1: coef.k1 <= cfg_data;
        rtld_pkg::REG_K2: coef.k2 <= cfg_data;
        rtld_pkg::REG_P1: coef.p1 <= cfg_data;
        rtld_pkg::REG_P2: coef.p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic            cvld [ITERATIONS+1];
  rtld_pkg::item_t citem [ITERATIONS+1];

  rtld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_kind   (kind),
    .in_u      (in_u),
    .in_v      (in_v),
    .out_valid (cvld[0]),
    .out_item  (citem[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    rtld_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .coef      (coef),
      .in_valid  (cvld[i]),
      .in_item   (citem[i]),
      .out_valid (cvld[i+1]),
      .out_item  (citem[i+1])
    );
  end

  rtld_pkg::item_t last;
  rtld_pkg::q32_t  rx_next, ry_next, rc_next;
  logic [1:0]      st_next;
  always_comb begin
    last = citem[ITERATIONS];
    if (last.kind == rtld_pkg::K_UNDIST) begin
      rx_next = last.cu;
      ry_next = last.cv;
      rc_next = '0;
      st_next = last.zd ? rtld_pkg::ST_ZDIV : (last.isat ? rtld_pkg::ST_SAT : rtld_pkg::ST_OK);
    end else begin
      rx_next = last.rx;
      ry_next = last.ry;
      rc_next = last.rc;
      st_next = last.fsat ? rtld_pkg::ST_SAT : rtld_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cvld[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_x   <= rx_next;
      result_y   <= ry_next;
      cross_term <= rc_next;
      status     <= st_next;
    end
  end

  `RTLD_ASSERT(a_zdiv_extreme, out_valid && status == rtld_pkg::ST_ZDIV, (result_x == rtld_pkg::Q_MAX || result_x == rtld_pkg::Q_MIN) && (result_y == rtld_pkg::Q_MAX || result_y == rtld_pkg::Q_MIN) && cross_term == '0, "zero divisor word not saturated")
  `RTLD_ASSERT(a_free_accept, !out_valid, !in_stall, "input stalled with empty output")
  `RTLD_ASSERT_NEXT(a_hold_blocked, !en, out_valid && $stable(result_x) && $stable(status), "blocked output word changed")

endmodule
